[rtl/cau_pkg.sv]
package cau_pkg;

  typedef logic [2:0] cmd_t;

  localparam cmd_t CMD_ADD  = 3'd0;
  localparam cmd_t CMD_SUB  = 3'd1;
  localparam cmd_t CMD_MUL  = 3'd2;
  localparam cmd_t CMD_DIV  = 3'd3;
  localparam cmd_t CMD_CONJ = 3'd4;
  localparam cmd_t CMD_MAG  = 3'd5;

  // Which back-end path carries an item.
  typedef enum logic [1:0] {
    CLS_DIRECT,
    CLS_MUL,
    CLS_DIV,
    CLS_MAG
  } cls_t;

  // Quotient and root digits produced by the back-end units.
  localparam int DIGITS = 33;

  // Depth of the queue between front and back (power of two).
  localparam int QDEPTH = 4;

  typedef struct packed {
    cls_t               cls;
    logic signed [31:0] a_re;
    logic signed [31:0] a_im;
    logic signed [31:0] b_re;
    logic signed [31:0] b_im;
    logic [31:0]        d_re;
    logic [31:0]        d_im;
    logic               d_ovf;
  } item_t;

  typedef struct packed {
    logic        ovf;
    logic [31:0] val;
  } sat_t;

  // Clamp a sign-magnitude value into a signed 32-bit word.
  function automatic sat_t sat32(input logic neg, input logic [65:0] mag);
    sat_t r;
    r.ovf = 1'b0;
    r.val = '0;
    if (!neg) begin
      if (mag > 66'h0_7FFF_FFFF) begin
        r.ovf = 1'b1;
        r.val = 32'h7FFF_FFFF;
      end else begin
        r.val = mag[31:0];
      end
    end else begin
      if (mag > 66'h0_8000_0000) begin
        r.ovf = 1'b1;
        r.val = 32'h8000_0000;
      end else begin
        r.val = 32'(~mag[31:0] + 32'd1);
      end
    end
    return r;
  endfunction

endpackage

[rtl/cau_front.sv]
module cau_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  output logic                full,
  input  logic [2:0]          in_command,
  input  logic signed [31:0]  in_a_re,
  input  logic signed [31:0]  in_a_im,
  input  logic signed [31:0]  in_b_re,
  input  logic signed [31:0]  in_b_im,
  input  logic                q_full,
  output logic                q_push,
  output cau_pkg::item_t      q_item
);

  cau_pkg::cls_t      cls_c;
  logic signed [33:0] v_re;
  logic signed [33:0] v_im;
  logic [33:0]        m_re;
  logic [33:0]        m_im;
  cau_pkg::sat_t      s_re;
  cau_pkg::sat_t      s_im;
  cau_pkg::item_t     item_c;
  cau_pkg::item_t     item_r;
  logic               valid_r;
  logic               accept;

  // Decode the command; add, sub and conjugate finish here.
  always_comb begin
    cls_c = cau_pkg::CLS_DIRECT;
    v_re  = '0;
    v_im  = '0;
    unique case (in_command)
      cau_pkg::CMD_ADD: begin
        v_re = 34'(in_a_re) + 34'(in_b_re);
        v_im = 34'(in_a_im) + 34'(in_b_im);
      end
      cau_pkg::CMD_SUB: begin
        v_re = 34'(in_a_re) - 34'(in_b_re);
        v_im = 34'(in_a_im) - 34'(in_b_im);
      end
      cau_pkg::CMD_MUL:  cls_c = cau_pkg::CLS_MUL;
      cau_pkg::CMD_DIV:  cls_c = cau_pkg::CLS_DIV;
      cau_pkg::CMD_CONJ: begin
        v_re = 34'(in_a_re);
        v_im = -34'(in_a_im);
      end
      cau_pkg::CMD_MAG:  cls_c = cau_pkg::CLS_MAG;
      default: ;
    endcase
  end

  assign m_re = v_re[33] ? 34'(-v_re) : 34'(v_re);
  assign m_im = v_im[33] ? 34'(-v_im) : 34'(v_im);
  assign s_re = cau_pkg::sat32(v_re[33], {32'b0, m_re});
  assign s_im = cau_pkg::sat32(v_im[33], {32'b0, m_im});

  always_comb begin
    item_c.cls   = cls_c;
    item_c.a_re  = in_a_re;
    item_c.a_im  = in_a_im;
    item_c.b_re  = in_b_re;
    item_c.b_im  = in_b_im;
    item_c.d_re  = s_re.val;
    item_c.d_im  = s_im.val;
    item_c.d_ovf = s_re.ovf | s_im.ovf;
  end

  assign full   = valid_r && q_full;
  assign accept = push && !full;
  assign q_push = valid_r && !q_full;
  assign q_item = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (!valid_r || !q_full) begin
      valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= item_c;
    end
  end

endmodule

[rtl/cau_fifo.sv]
module cau_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  cau_pkg::item_t wr_item,
  output logic           full,
  input  logic           pop,
  output logic           empty,
  output cau_pkg::item_t rd_item
);

  localparam int PW = $clog2(cau_pkg::QDEPTH);

  cau_pkg::item_t mem_r [cau_pkg::QDEPTH];
  logic [PW-1:0]  wr_ptr_r;
  logic [PW-1:0]  rd_ptr_r;
  logic [PW:0]    cnt_r;
  logic           do_push;
  logic           do_pop;

  assign full    = (cnt_r == (PW+1)'(cau_pkg::QDEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_item = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_item;
    end
  end

endmodule

[rtl/cau_div.sv]
// Pipelined restoring divider: round(n * 2^FRAC_BITS / d), one quotient bit a stage.
module cau_div #(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] n,
  input  logic [63:0] d,
  output logic [34:0] q_mag
);

  localparam int DG = cau_pkg::DIGITS;
  localparam int NW = 64 + FRAC_BITS;
  localparam int CW = 64 + DG;

  logic [NW-1:0] num;
  logic          huge_c;

  logic [63:0]   r_r    [DG+1];
  logic [DG-1:0] low_r  [DG+1];
  logic [63:0]   d_r    [DG+1];
  logic          huge_r [DG+1];
  logic [DG-1:0] q_r    [DG+1];
  logic          rnd;

  assign num    = {n, {FRAC_BITS{1'b0}}};
  // Quotient would need more than DIGITS bits: saturates anyway.
  assign huge_c = (CW'(num) >= {d, {DG{1'b0}}});

  always_ff @(posedge clk) begin
    if (en) begin
      r_r[0]    <= 64'(num[NW-1:DG]);
      low_r[0]  <= num[DG-1:0];
      d_r[0]    <= d;
      huge_r[0] <= huge_c;
      q_r[0]    <= '0;
    end
  end

  for (genvar k = 1; k <= DG; k++) begin : g_stage
    logic [64:0] t;
    logic        ge;
    assign t  = {r_r[k-1], low_r[k-1][DG-1]};
    assign ge = (t >= {1'b0, d_r[k-1]});
    always_ff @(posedge clk) begin
      if (en) begin
        r_r[k]    <= ge ? 64'(t - {1'b0, d_r[k-1]}) : t[63:0];
        low_r[k]  <= {low_r[k-1][DG-2:0], 1'b0};
        d_r[k]    <= d_r[k-1];
        huge_r[k] <= huge_r[k-1];
        q_r[k]    <= {q_r[k-1][DG-2:0], ge};
      end
    end
  end

  // Round half up: remainder at least half the divisor.
  assign rnd = ({r_r[DG], 1'b0} >= {1'b0, d_r[DG]});

  always_ff @(posedge clk) begin
    if (en) begin
      q_mag <= huge_r[DG] ? {1'b1, 34'b0} : 35'(q_r[DG]) + 35'(rnd);
    end
  end

endmodule

[rtl/cau_sqrt.sv]
// Pipelined digit-by-digit square root, rounded to the nearest integer.
module cau_sqrt (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] s,
  output logic [33:0] root
);

  localparam int DG = cau_pkg::DIGITS;
  localparam int RW = 2 * DG;

  logic [RW-1:0] rad_r  [DG+1];
  logic [35:0]   rem_r  [DG+1];
  logic [DG-1:0] root_r [DG+1];

  always_ff @(posedge clk) begin
    if (en) begin
      rad_r[0]  <= RW'(s);
      rem_r[0]  <= '0;
      root_r[0] <= '0;
    end
  end

  for (genvar k = 1; k <= DG; k++) begin : g_stage
    logic [37:0] cur;
    logic [37:0] trial;
    logic        ge;
    assign cur   = {rem_r[k-1], rad_r[k-1][RW-1:RW-2]};
    assign trial = 38'({root_r[k-1], 2'b01});
    assign ge    = (cur >= trial);
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= ge ? 36'(cur - trial) : cur[35:0];
        root_r[k] <= {root_r[k-1][DG-2:0], ge};
        rad_r[k]  <= {rad_r[k-1][RW-3:0], 2'b00};
      end
    end
  end

  // Remainder above the root means the exact root lies past the halfway point.
  always_ff @(posedge clk) begin
    if (en) begin
      root <= 34'(root_r[DG]) + 34'(rem_r[DG] > 36'(root_r[DG]));
    end
  end

endmodule

[rtl/cau_back.sv]
module cau_back #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_empty,
  input  cau_pkg::item_t     q_item,
  output logic               q_pop,
  input  logic               pop,
  output logic               empty,
  output logic signed [31:0] out_res_re,
  output logic signed [31:0] out_res_im,
  output logic               out_div_by_zero,
  output logic               out_overflow
);

  localparam int LAT = cau_pkg::DIGITS + 2;

  typedef struct packed {
    cau_pkg::cls_t cls;
    logic          neg_re;
    logic          neg_im;
    logic          dz;
    logic [63:0]   v_re;
    logic [63:0]   v_im;
    logic          d_ovf;
  } meta_t;

  logic adv;

  // Product stage
  logic               v1_r;
  cau_pkg::cls_t      cls1_r;
  logic signed [63:0] p_rr_r, p_ii_r, p_ri_r, p_ir_r, sq0_r, sq1_r;
  logic [31:0]        d_re1_r, d_im1_r;
  logic               d_ovf1_r;
  logic signed [31:0] sx0, sx1;

  // Combine stage
  logic               v2_r;
  cau_pkg::cls_t      cls2_r;
  logic signed [65:0] c_re, c_im;
  logic [65:0]        cm_re, cm_im;
  logic               neg_re2_r, neg_im2_r;
  logic [63:0]        mag_re2_r, mag_im2_r, den2_r;
  logic [31:0]        d_re2_r, d_im2_r;
  logic               d_ovf2_r;

  meta_t              meta0;
  meta_t              meta_r [LAT];
  logic [LAT-1:0]     mv_r;
  meta_t              ml;

  logic [34:0]        q_re, q_im;
  logic [33:0]        root;

  cau_pkg::sat_t      s_re, s_im;
  logic [31:0]        f_re, f_im;
  logic               f_dz, f_ovf;
  logic               out_valid_r;
  logic               out_load;

  assign out_load = !out_valid_r || pop;
  // Whole pipeline moves together; it holds only when a finished result is blocked.
  assign adv      = out_load || !mv_r[LAT-1];
  assign q_pop    = adv && !q_empty;
  assign empty    = !out_valid_r;

  assign sx0 = (q_item.cls == cau_pkg::CLS_MAG) ? q_item.a_re : q_item.b_re;
  assign sx1 = (q_item.cls == cau_pkg::CLS_MAG) ? q_item.a_im : q_item.b_im;

  always_ff @(posedge clk) begin
    if (adv) begin
      cls1_r   <= q_item.cls;
      p_rr_r   <= q_item.a_re * q_item.b_re;
      p_ii_r   <= q_item.a_im * q_item.b_im;
      p_ri_r   <= q_item.a_re * q_item.b_im;
      p_ir_r   <= q_item.a_im * q_item.b_re;
      sq0_r    <= sx0 * sx0;
      sq1_r    <= sx1 * sx1;
      d_re1_r  <= q_item.d_re;
      d_im1_r  <= q_item.d_im;
      d_ovf1_r <= q_item.d_ovf;
    end
  end

  always_comb begin
    if (cls1_r == cau_pkg::CLS_DIV) begin
      c_re = 66'(p_rr_r) + 66'(p_ii_r);
      c_im = 66'(p_ir_r) - 66'(p_ri_r);
    end else begin
      c_re = 66'(p_rr_r) - 66'(p_ii_r);
      c_im = 66'(p_ri_r) + 66'(p_ir_r);
    end
  end

  assign cm_re = c_re[65] ? 66'(-c_re) : 66'(c_re);
  assign cm_im = c_im[65] ? 66'(-c_im) : 66'(c_im);

  always_ff @(posedge clk) begin
    if (adv) begin
      cls2_r    <= cls1_r;
      neg_re2_r <= c_re[65];
      neg_im2_r <= c_im[65];
      mag_re2_r <= cm_re[63:0];
      mag_im2_r <= cm_im[63:0];
      den2_r    <= 64'(unsigned'(sq0_r)) + 64'(unsigned'(sq1_r));
      d_re2_r   <= d_re1_r;
      d_im2_r   <= d_im1_r;
      d_ovf2_r  <= d_ovf1_r;
    end
  end

  // Sideband that travels beside the divider and root pipelines.
  always_comb begin
    meta0.cls    = cls2_r;
    meta0.neg_re = neg_re2_r;
    meta0.neg_im = neg_im2_r;
    meta0.dz     = (den2_r == '0);
    meta0.d_ovf  = d_ovf2_r;
    if (cls2_r == cau_pkg::CLS_MUL) begin
      meta0.v_re = (mag_re2_r >> FRAC_BITS) + 64'(mag_re2_r[FRAC_BITS-1]);
      meta0.v_im = (mag_im2_r >> FRAC_BITS) + 64'(mag_im2_r[FRAC_BITS-1]);
    end else begin
      meta0.v_re = {32'b0, d_re2_r};
      meta0.v_im = {32'b0, d_im2_r};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      meta_r[0] <= meta0;
      for (int i = 1; i < LAT; i++) begin
        meta_r[i] <= meta_r[i-1];
      end
    end
  end

  cau_div #(.FRAC_BITS(FRAC_BITS)) u_div_re (
    .clk   (clk),
    .en    (adv),
    .n     (mag_re2_r),
    .d     (den2_r),
    .q_mag (q_re)
  );

  cau_div #(.FRAC_BITS(FRAC_BITS)) u_div_im (
    .clk   (clk),
    .en    (adv),
    .n     (mag_im2_r),
    .d     (den2_r),
    .q_mag (q_im)
  );

  cau_sqrt u_sqrt (
    .clk  (clk),
    .en   (adv),
    .s    (den2_r),
    .root (root)
  );

  assign ml = meta_r[LAT-1];

  // Final selection and saturation.
  always_comb begin
    s_re  = '0;
    s_im  = '0;
    f_re  = '0;
    f_im  = '0;
    f_dz  = 1'b0;
    f_ovf = 1'b0;
    unique case (ml.cls)
      cau_pkg::CLS_DIRECT: begin
        f_re  = ml.v_re[31:0];
        f_im  = ml.v_im[31:0];
        f_ovf = ml.d_ovf;
      end
      cau_pkg::CLS_MUL: begin
        s_re  = cau_pkg::sat32(ml.neg_re, {2'b0, ml.v_re});
        s_im  = cau_pkg::sat32(ml.neg_im, {2'b0, ml.v_im});
        f_re  = s_re.val;
        f_im  = s_im.val;
        f_ovf = s_re.ovf | s_im.ovf;
      end
      cau_pkg::CLS_DIV: begin
        if (ml.dz) begin
          f_dz = 1'b1;
        end else begin
          s_re  = cau_pkg::sat32(ml.neg_re, {31'b0, q_re});
          s_im  = cau_pkg::sat32(ml.neg_im, {31'b0, q_im});
          f_re  = s_re.val;
          f_im  = s_im.val;
          f_ovf = s_re.ovf | s_im.ovf;
        end
      end
      cau_pkg::CLS_MAG: begin
        s_re  = cau_pkg::sat32(1'b0, {32'b0, root});
        f_re  = s_re.val;
        f_ovf = s_re.ovf;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      mv_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (adv) begin
        v1_r <= !q_empty;
        v2_r <= v1_r;
        mv_r <= {mv_r[LAT-2:0], v2_r};
      end
      if (out_load) begin
        out_valid_r <= mv_r[LAT-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load && mv_r[LAT-1]) begin
      out_res_re      <= f_re;
      out_res_im      <= f_im;
      out_div_by_zero <= f_dz;
      out_overflow    <= f_ovf;
    end
  end

endmodule

[rtl/complex_arithmetic_unit.sv]
// Complex arithmetic unit on signed fixed-point operands (FRAC_BITS fraction bits):
// add, subtract, multiply, divide, conjugate of a and magnitude of a, with
// saturation and an overflow flag; a divide by zero returns zero with
// div_by_zero set, and unused command codes return zero with both flags clear.
// Both sides behave as queues: push/full in, empty/pop out. A new item can be
// taken every cycle while full is low, and results leave one per cycle while
// pop stays high. From the accepting edge a result passes the front register,
// the queue, a product stage, a combine stage, 35 stages set by the 33-digit
// pipelined dividers and square root plus their entry and rounding registers,
// and the output register. Multiply, divide and magnitude round to nearest
// with ties away from zero.
module complex_arithmetic_unit #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  logic [2:0]         in_command,
  input  logic signed [31:0] in_a_re,
  input  logic signed [31:0] in_a_im,
  input  logic signed [31:0] in_b_re,
  input  logic signed [31:0] in_b_im,
  output logic               empty,
  input  logic               pop,
  output logic signed [31:0] out_res_re,
  output logic signed [31:0] out_res_im,
  output logic               out_div_by_zero,
  output logic               out_overflow
);

  logic           q_push;
  logic           q_full;
  logic           q_pop;
  logic           q_empty;
  cau_pkg::item_t q_wr_item;
  cau_pkg::item_t q_rd_item;

  // Front: take the transfer, decode it, finish add/sub/conjugate.
  cau_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .full       (full),
    .in_command (in_command),
    .in_a_re    (in_a_re),
    .in_a_im    (in_a_im),
    .in_b_re    (in_b_re),
    .in_b_im    (in_b_im),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_item     (q_wr_item)
  );

  // Short queue: lets the front keep accepting while the back holds.
  cau_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wr_item (q_wr_item),
    .full    (q_full),
    .pop     (q_pop),
    .empty   (q_empty),
    .rd_item (q_rd_item)
  );

  // Back: multipliers, dividers and root, then saturation into the output register.
  cau_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_empty         (q_empty),
    .q_item          (q_rd_item),
    .q_pop           (q_pop),
    .pop             (pop),
    .empty           (empty),
    .out_res_re      (out_res_re),
    .out_res_im      (out_res_im),
    .out_div_by_zero (out_div_by_zero),
    .out_overflow    (out_overflow)
  );

  // The inner queue never reports full and empty at once.
  a_q_flags : assert property (@(posedge clk) disable iff (!rst_n)
    !(q_full && q_empty))
    else $error("inner queue full and empty together");

  // The front never offers a transfer to a full queue.
  a_q_push : assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("push into full inner queue");

  // Input side stalls only while the inner queue is full.
  a_full : assert property (@(posedge clk) disable iff (!rst_n)
    full |-> q_full)
    else $error("input stalled with room in inner queue");

  // A zero divisor gives zero with no overflow.
  a_dz : assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_div_by_zero) |->
      (out_res_re == '0 && out_res_im == '0 && !out_overflow))
    else $error("divide by zero result not cleared");

endmodule
